[hw/rtl/qdlm_pkg.sv]
// ----------------------------------------------------------------------------
// qdlm_pkg
// Shared types and constants of the quantized dense-layer MAC unit: the
// configuration register map, the configuration bundle and the request
// that passes from the accumulator to the requantization pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qdlm_pkg;

    // Fixed field widths.
    localparam int unsigned ActWidth   = 8;
    localparam int unsigned WgtWidth   = 8;
    localparam int unsigned BiasWidth  = 8;
    localparam int unsigned BnWidth    = 64;
    localparam int unsigned OutWidth   = 8;
    localparam int unsigned ShiftWidth = 6;
    localparam int unsigned MultWidth  = 16;
    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned WideWidth  = 64;
    localparam int unsigned HalfWidth  = 32;

    // Largest output code; larger results saturate here.
    localparam logic [OutWidth-1:0] OutMax = 8'd255;

    // Configuration register indexes.
    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_BIAS_ENABLE        = 3'd0,
        CFG_RELU_ENABLE        = 3'd1,
        CFG_BATCHNORM_ENABLE   = 3'd2,
        CFG_RESULT_SHIFT       = 3'd3,
        CFG_REQUANT_MULTIPLIER = 3'd4
    } t_cfg_idx;

    // Configuration register contents.
    typedef struct packed {
        logic                  bias_enable;
        logic                  relu_enable;
        logic                  batchnorm_enable;
        logic [ShiftWidth-1:0] result_shift;
        logic [MultWidth-1:0]  requant_multiplier;
    } t_cfg;

    // One finished dot product with its requantization operands:
    // the result is ((sum * scale + offset) mod 2^64) >>> shift.
    typedef struct packed {
        logic [WideWidth-1:0]  sum;
        logic [WideWidth-1:0]  scale;
        logic [WideWidth-1:0]  offset;
        logic [ShiftWidth-1:0] shift;
    } t_requant_req;

endpackage

`default_nettype wire

[hw/rtl/qdlm_in_if.sv]
// ----------------------------------------------------------------------------
// qdlm_in_if
// Input channel: one activation/weight pair with the neuron's bias,
// batch-norm operands and end-of-neuron mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface qdlm_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         activation;
    logic signed [7:0]  weight;
    logic signed [7:0]  neuron_bias;
    logic signed [63:0] bn_scale;
    logic signed [63:0] bn_offset;
    logic               last_element;

    modport source (
        output valid, activation, weight, neuron_bias, bn_scale, bn_offset,
               last_element,
        input  ready
    );

    modport sink (
        input  valid, activation, weight, neuron_bias, bn_scale, bn_offset,
               last_element,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/qdlm_out_if.sv]
// ----------------------------------------------------------------------------
// qdlm_out_if
// Output channel: one requantized, saturated activation byte per neuron.
// ----------------------------------------------------------------------------
`default_nettype none

interface qdlm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;

    modport source (
        output valid, out_value,
        input  ready
    );

    modport sink (
        input  valid, out_value,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/quantized_dense_layer_mac_unit.sv]
// ----------------------------------------------------------------------------
// quantized_dense_layer_mac_unit
// Streams activation/weight pairs of a dense layer and emits one saturated
// 8-bit output activation per neuron.
//
// Channels: i_in carries one activation/weight pair per transaction, with
// the neuron's bias (used on its first pair), batch-norm scale and offset
// (used on its last pair) and the last_element mark. o_out carries one
// requantized byte per neuron. The configuration port writes one register
// per cycle at i_cfg_index while i_cfg_we is high; write it only when idle.
// Throughput: one input transaction per cycle while the request register is
// empty or draining. The accumulator feedback is a single add, and the
// requantization path is pipelined. The neuron's last pair loads the
// request register, whose contents pass through the multiply stage (32x32
// partial products), the sum stage (64-bit recombine and offset add) and
// the output register (shift and clip). Stall: every stage holds and fills
// bubbles independently, so the input keeps being accepted while results
// wait until all stages are occupied.
// Reset: registers return to their reset values, the accumulator clears
// and the next pair starts a new neuron.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_dense_layer_mac_unit #(
    parameter int unsigned ACC_WIDTH = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [qdlm_pkg::CfgIdxWidth-1:0]   i_cfg_index,
    input  wire [qdlm_pkg::CfgDataWidth-1:0]  i_cfg_data,
    qdlm_in_if.sink                           i_in,
    qdlm_out_if.source                        o_out
);
    import qdlm_pkg::*;

    t_cfg         r_cfg;
    logic         w_req_valid;
    logic         w_req_ready;
    t_requant_req w_req;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bias_enable        <= 1'b1;
            r_cfg.relu_enable        <= 1'b1;
            r_cfg.batchnorm_enable   <= 1'b0;
            r_cfg.result_shift       <= '0;
            r_cfg.requant_multiplier <= MultWidth'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BIAS_ENABLE: begin
                    r_cfg.bias_enable <= i_cfg_data[0];
                end
                CFG_RELU_ENABLE: begin
                    r_cfg.relu_enable <= i_cfg_data[0];
                end
                CFG_BATCHNORM_ENABLE: begin
                    r_cfg.batchnorm_enable <= i_cfg_data[0];
                end
                CFG_RESULT_SHIFT: begin
                    r_cfg.result_shift <= i_cfg_data[ShiftWidth-1:0];
                end
                CFG_REQUANT_MULTIPLIER: begin
                    r_cfg.requant_multiplier <= i_cfg_data[MultWidth-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Multiply-accumulate front end.
    qdlm_accum #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_ready (w_req_ready)
    );

    // Requantization pipeline and output register.
    qdlm_requant u_requant (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_ready (w_req_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[hw/rtl/qdlm_accum.sv]
// ----------------------------------------------------------------------------
// qdlm_accum
// Multiply-accumulate front end. Every accepted transaction adds one
// activation*weight product into the wrapping accumulator; the transaction
// that closes a neuron loads a requantization request register.
// ----------------------------------------------------------------------------
`default_nettype none

module qdlm_accum #(
    parameter int unsigned ACC_WIDTH = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire qdlm_pkg::t_cfg   i_cfg,
    qdlm_in_if.sink               i_in,
    output logic                  o_req_valid,
    output qdlm_pkg::t_requant_req o_req,
    input  wire                   i_req_ready
);
    import qdlm_pkg::*;

    localparam int unsigned ProdWidth = ActWidth + WgtWidth + 1;

    logic                        w_accept;
    logic signed [ProdWidth-1:0] w_prod;
    logic [ACC_WIDTH-1:0]        w_base;
    logic [ACC_WIDTH-1:0]        n_acc;
    logic [ACC_WIDTH-1:0]        r_acc;
    logic                        r_at_start;
    logic                        r_req_valid;
    t_requant_req                r_req;
    t_requant_req                n_req;

    // The request register frees up when empty or when it is being drained.
    assign i_in.ready = !r_req_valid || i_req_ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Unsigned activation times signed weight.
    assign w_prod = $signed({1'b0, i_in.activation}) * i_in.weight;

    // Starting point: bias or zero on the first element, else the running sum.
    always_comb begin
        if (r_at_start) begin
            if (i_cfg.bias_enable) begin
                w_base = {{(ACC_WIDTH-BiasWidth){i_in.neuron_bias[BiasWidth-1]}},
                          i_in.neuron_bias};
            end else begin
                w_base = '0;
            end
        end else begin
            w_base = r_acc;
        end
        n_acc = w_base + {{(ACC_WIDTH-ProdWidth){w_prod[ProdWidth-1]}}, w_prod};
    end

    // Operand selection for the shared multiply-add-shift path.
    always_comb begin
        n_req.sum    = {{(WideWidth-ACC_WIDTH){n_acc[ACC_WIDTH-1]}}, n_acc};
        n_req.shift  = i_cfg.result_shift;
        if (i_cfg.relu_enable && i_cfg.batchnorm_enable) begin
            n_req.scale  = i_in.bn_scale;
            n_req.offset = i_in.bn_offset;
        end else if (i_cfg.relu_enable) begin
            n_req.scale  = {{(WideWidth-MultWidth){1'b0}}, i_cfg.requant_multiplier};
            n_req.offset = '0;
        end else begin
            n_req.scale  = WideWidth'(1);
            n_req.offset = '0;
        end
    end

    // Accumulator and neuron-start flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_at_start <= 1'b1;
        end else if (w_accept) begin
            r_acc      <= n_acc;
            r_at_start <= i_in.last_element;
        end
    end

    // Request register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (w_accept && i_in.last_element) begin
            r_req_valid <= 1'b1;
        end else if (i_req_ready) begin
            r_req_valid <= 1'b0;
        end
    end

    // Request payload.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.last_element) begin
            r_req <= n_req;
        end
    end

    assign o_req_valid = r_req_valid;
    assign o_req       = r_req;

endmodule

`default_nettype wire

[hw/rtl/qdlm_requant.sv]
// ----------------------------------------------------------------------------
// qdlm_requant
// Requantization pipeline: 64-bit wrapping multiply split into 32-bit
// partial products, offset add, arithmetic shift and saturation to 0..255.
// Each stage moves on whenever the stage after it is empty or moving.
// ----------------------------------------------------------------------------
`default_nettype none

module qdlm_requant (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_req_valid,
    input  wire qdlm_pkg::t_requant_req i_req,
    output logic                   o_req_ready,
    qdlm_out_if.source             o_out
);
    import qdlm_pkg::*;

    logic                  w_en_out;
    logic                  w_en_sum;
    logic                  w_en_mul;

    logic [WideWidth-1:0]  w_pp_ll;
    logic [HalfWidth-1:0]  w_pp_lh;
    logic [HalfWidth-1:0]  w_pp_hl;
    logic [HalfWidth-1:0]  w_cross;
    logic [WideWidth-1:0]  n_val;
    logic signed [WideWidth-1:0] w_shifted;
    logic [OutWidth-1:0]   n_out;

    logic                  r_mul_valid;
    logic [WideWidth-1:0]  r_pp_ll;
    logic [HalfWidth-1:0]  r_pp_lh;
    logic [HalfWidth-1:0]  r_pp_hl;
    logic [WideWidth-1:0]  r_mul_offset;
    logic [ShiftWidth-1:0] r_mul_shift;

    logic                  r_sum_valid;
    logic [WideWidth-1:0]  r_val;
    logic [ShiftWidth-1:0] r_sum_shift;

    logic                  r_out_valid;
    logic [OutWidth-1:0]   r_out;

    // Stage enables, from the output backwards.
    assign w_en_out    = !r_out_valid || o_out.ready;
    assign w_en_sum    = !r_sum_valid || w_en_out;
    assign w_en_mul    = !r_mul_valid || w_en_sum;
    assign o_req_ready = w_en_mul;

    // Partial products; only the low half of the cross terms survives mod 2^64.
    assign w_pp_ll = i_req.sum[HalfWidth-1:0] * i_req.scale[HalfWidth-1:0];
    assign w_pp_lh = i_req.sum[HalfWidth-1:0] * i_req.scale[WideWidth-1:HalfWidth];
    assign w_pp_hl = i_req.sum[WideWidth-1:HalfWidth] * i_req.scale[HalfWidth-1:0];

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (w_en_mul) begin
            r_mul_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_mul && i_req_valid) begin
            r_pp_ll      <= w_pp_ll;
            r_pp_lh      <= w_pp_lh;
            r_pp_hl      <= w_pp_hl;
            r_mul_offset <= i_req.offset;
            r_mul_shift  <= i_req.shift;
        end
    end

    // Recombine the partial products and add the offset.
    assign w_cross = r_pp_lh + r_pp_hl;
    assign n_val   = r_pp_ll + {w_cross, {HalfWidth{1'b0}}} + r_mul_offset;

    // Sum stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (w_en_sum) begin
            r_sum_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_sum && r_mul_valid) begin
            r_val       <= n_val;
            r_sum_shift <= r_mul_shift;
        end
    end

    // Arithmetic shift and saturation to the unsigned byte range.
    assign w_shifted = $signed(r_val) >>> r_sum_shift;

    always_comb begin
        if (w_shifted[WideWidth-1]) begin
            n_out = '0;
        end else if (|w_shifted[WideWidth-2:OutWidth]) begin
            n_out = OutMax;
        end else begin
            n_out = w_shifted[OutWidth-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_sum_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out;

endmodule

`default_nettype wire
